@@ rtl/core/rsc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsc_pkg
// Shared types, character codes and alphabet helpers for the radix string
// converter.
// ============================================================================
package rsc_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int SYMS        = 16;
    localparam int STACK_DEPTH = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    typedef logic [7:0]          t_char;
    typedef t_char [SYMS-1:0]    t_sym_array;
    typedef logic [3:0]          t_digit;
    typedef logic [4:0]          t_len;
    typedef logic [2:0]          t_cfg_index;
    typedef logic [COUNT_W-1:0]  t_count;

    localparam t_cfg_index CFG_SRC_LO  = 3'd0;
    localparam t_cfg_index CFG_SRC_HI  = 3'd1;
    localparam t_cfg_index CFG_SRC_LEN = 3'd2;
    localparam t_cfg_index CFG_TGT_LO  = 3'd3;
    localparam t_cfg_index CFG_TGT_HI  = 3'd4;
    localparam t_cfg_index CFG_TGT_LEN = 3'd5;

    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;

    typedef struct packed {
        logic   hit;
        t_digit idx;
    } t_lookup;

    typedef struct packed {
        logic active;
        logic last;
    } t_acc_status;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        t_digit      rem;
    } t_div_status;

    function automatic logic is_space(t_char c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic alpha_ok(t_sym_array s, t_len len);
        logic ok;
        ok = (len >= 5'd2) && (len <= t_len'(MAX_RADIX));
        for (int i = 0; i < SYMS; i++) begin
            if (t_len'(i) < len) begin
                if (s[i] == CH_NUL || s[i] == CH_PLUS || s[i] == CH_MINUS ||
                    is_space(s[i])) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < SYMS; j++) begin
                    if (t_len'(j) < len && s[j] == s[i]) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    // last matching symbol wins
    function automatic t_lookup digit_of(t_sym_array s, t_len len, t_char c);
        t_lookup r;
        r = '0;
        for (int i = 0; i < SYMS; i++) begin
            if (t_len'(i) < len && t_len'(i) < t_len'(MAX_RADIX) && s[i] == c) begin
                r.hit = 1'b1;
                r.idx = t_digit'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/rsc_accum.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsc_accum
// Byte-serial multiply-add of the running total: total * len + digit,
// one byte of the total per cycle, wrapping at 32 bits.
// ============================================================================
module rsc_accum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_clear,
    input  rsc_pkg::t_digit        i_digit,
    input  rsc_pkg::t_len          i_len,
    output logic [31:0]            o_total,
    output rsc_pkg::t_acc_status   o_status
);
    import rsc_pkg::*;

    logic [31:0] r_total;
    logic [4:0]  r_carry;
    logic [1:0]  r_cnt;
    logic        r_active;
    logic [12:0] n_prod;

    assign n_prod = ({5'd0, r_total[7:0]} * {8'd0, i_len}) + {8'd0, r_carry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_cnt    <= '0;
            r_active <= 1'b0;
        end else begin
            if (r_active) begin
                r_total <= {n_prod[7:0], r_total[31:8]};
                r_carry <= n_prod[12:8];
                r_cnt   <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_active <= 1'b0;
                end
            end
            if (i_clear) begin
                r_total <= '0;
            end
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_carry  <= {1'b0, i_digit};
            end
        end
    end

    assign o_total         = r_total;
    assign o_status.active = r_active;
    assign o_status.last   = r_active && (r_cnt == 2'd3);

endmodule

@@ rtl/core/rsc_divider.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsc_divider
// Bit-serial restoring division of a 32-bit magnitude by the target radix,
// one quotient bit per cycle.
// ============================================================================
module rsc_divider (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [31:0]            i_value,
    input  rsc_pkg::t_len          i_radix,
    output rsc_pkg::t_div_status   o_status
);
    import rsc_pkg::*;

    logic [31:0] r_quot;
    logic [4:0]  r_rem;
    logic [4:0]  r_cnt;
    logic        r_active;
    logic        r_done;
    logic [5:0]  n_trial;
    logic [5:0]  n_diff;
    logic        n_ge;
    logic [4:0]  n_rem;

    assign n_trial = {r_rem, r_quot[31]};
    assign n_ge    = n_trial >= {1'b0, i_radix};
    assign n_diff  = n_trial - {1'b0, i_radix};
    assign n_rem   = n_ge ? n_diff[4:0] : n_trial[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_quot   <= i_value;
                r_rem    <= '0;
                r_cnt    <= '0;
                r_active <= 1'b1;
            end else if (r_active) begin
                r_quot <= {r_quot[30:0], n_ge};
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.quot = r_quot;
    assign o_status.rem  = r_rem[3:0];

endmodule

@@ rtl/core/rsc_digit_stack.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsc_digit_stack
// Shift-register stack that turns least-significant-first digits into
// most-significant-first order.
// ============================================================================
module rsc_digit_stack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_pop,
    input  rsc_pkg::t_digit   i_digit,
    output rsc_pkg::t_digit   o_top,
    output rsc_pkg::t_count   o_count
);
    import rsc_pkg::*;

    t_digit [STACK_DEPTH-1:0] r_data;
    t_count                   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push) begin
            r_data  <= {r_data[STACK_DEPTH-2:0], i_digit};
            r_count <= r_count + t_count'(1);
        end else if (i_pop) begin
            r_data  <= {t_digit'(0), r_data[STACK_DEPTH-1:1]};
            r_count <= r_count - t_count'(1);
        end
    end

    assign o_top   = r_data[0];
    assign o_count = r_count;

endmodule

@@ rtl/core/radix_string_converter.sv @@
`timescale 1ns / 1ps
// ============================================================================
// radix_string_converter
// Reads a signed number one character per item in a configurable source
// alphabet and writes it back out in a configurable target alphabet.
// ============================================================================
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+--------------------
// input     | start, i_char_in, busy                    | start & !busy
// result    | o_valid, o_char_out, o_last, o_invalid    | o_valid, one cycle
// config    | i_cfg_valid, i_cfg_index, i_cfg_data      | valid & o_cfg_ready
//
// whitespace and sign items are taken directly in the idle state; a digit item
// goes through the byte-serial multiply-add, and busy holds off the next item.
// a terminating item passes through S_TERM and then S_DIV, where each target digit
// takes a 32-step bit-serial division plus a push, then S_EMIT gives one result per cycle.
// reset is synchronous and active low; it clears the control state, the configuration and the number.
// results cannot be stalled; each is shown for exactly one cycle.
// ============================================================================
module radix_string_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [7:0]            i_char_in,
    output logic                  busy,
    output logic                  o_valid,
    output logic [7:0]            o_char_out,
    output logic                  o_last,
    output logic                  o_invalid,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  rsc_pkg::t_cfg_index   i_cfg_index,
    input  logic [63:0]           i_cfg_data
);
    import rsc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TERM = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [63:0] r_src_lo, r_src_hi, r_tgt_lo, r_tgt_hi;
    t_len        r_src_len, r_tgt_len;
    logic        r_ok;
    logic [1:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic        r_parity, n_parity;
    logic        r_out_valid, n_out_valid;
    t_char       r_char, n_char;
    logic        r_last, n_last;
    logic        r_invalid, n_invalid;

    t_sym_array  src_syms, tgt_syms;
    t_lookup     lookup;
    logic        accept;
    logic [31:0] total, neg_total, mag;
    logic        sign;
    logic        acc_start, acc_clear, div_load, push, pop;
    logic [31:0] div_value;
    t_acc_status acc_status;
    t_div_status div_status;
    t_digit      stack_top;
    t_count      stack_count;

    assign src_syms  = t_sym_array'({r_src_hi, r_src_lo});
    assign tgt_syms  = t_sym_array'({r_tgt_hi, r_tgt_lo});
    assign lookup    = digit_of(src_syms, r_src_len, i_char_in);
    assign busy      = (r_state != S_IDLE) || (acc_status.active && !acc_status.last);
    assign accept    = start && !busy;
    assign neg_total = 32'd0 - total;
    assign sign      = r_parity ? neg_total[31] : total[31];
    assign mag       = (r_parity ^ sign) ? neg_total : total;

    rsc_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (acc_start),
        .i_clear  (acc_clear),
        .i_digit  (lookup.idx),
        .i_len    (r_src_len),
        .o_total  (total),
        .o_status (acc_status)
    );

    rsc_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (div_load),
        .i_value  (div_value),
        .i_radix  (r_tgt_len),
        .o_status (div_status)
    );

    rsc_digit_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .i_digit (div_status.rem),
        .o_top   (stack_top),
        .o_count (stack_count)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_parity    = r_parity;
        n_out_valid = 1'b0;
        n_char      = r_char;
        n_last      = r_last;
        n_invalid   = r_invalid;
        acc_start   = 1'b0;
        acc_clear   = 1'b0;
        div_load    = 1'b0;
        div_value   = mag;
        push        = 1'b0;
        pop         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (r_phase == PH_SPACE && is_space(i_char_in)) begin
                        n_phase = PH_SPACE;
                    end else if ((r_phase == PH_SPACE || r_phase == PH_SIGN) &&
                                 (i_char_in == CH_PLUS || i_char_in == CH_MINUS)) begin
                        n_parity = r_parity ^ (i_char_in == CH_MINUS);
                        n_phase  = PH_SIGN;
                    end else if (lookup.hit) begin
                        acc_start = 1'b1;
                        n_phase   = PH_DIGIT;
                    end else begin
                        n_state = S_TERM;
                    end
                end
            end
            S_TERM: begin
                acc_clear   = 1'b1;
                n_phase     = PH_SPACE;
                n_parity    = 1'b0;
                n_out_valid = 1'b1;
                priority if (!r_ok) begin
                    n_char    = CH_NUL;
                    n_last    = 1'b1;
                    n_invalid = 1'b1;
                    n_state   = S_IDLE;
                end else if (total == 32'd0) begin
                    n_char    = tgt_syms[0];
                    n_last    = 1'b1;
                    n_invalid = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_out_valid = sign;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                    n_invalid   = 1'b0;
                    div_load    = 1'b1;
                    div_value   = mag;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    push = 1'b1;
                    if (div_status.quot == 32'd0) begin
                        n_state = S_EMIT;
                    end else begin
                        div_load  = 1'b1;
                        div_value = div_status.quot;
                    end
                end
            end
            S_EMIT: begin
                pop         = 1'b1;
                n_out_valid = 1'b1;
                n_char      = tgt_syms[stack_top];
                n_last      = (stack_count == t_count'(1));
                n_invalid   = 1'b0;
                if (stack_count == t_count'(1)) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SPACE;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_parity    <= n_parity;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_last    <= n_last;
        r_invalid <= n_invalid;
        r_ok      <= alpha_ok(src_syms, r_src_len) && alpha_ok(tgt_syms, r_tgt_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_lo  <= '0;
            r_src_hi  <= '0;
            r_src_len <= '0;
            r_tgt_lo  <= '0;
            r_tgt_hi  <= '0;
            r_tgt_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SRC_LO:  r_src_lo  <= i_cfg_data;
                CFG_SRC_HI:  r_src_hi  <= i_cfg_data;
                CFG_SRC_LEN: r_src_len <= i_cfg_data[4:0];
                CFG_TGT_LO:  r_tgt_lo  <= i_cfg_data;
                CFG_TGT_HI:  r_tgt_hi  <= i_cfg_data;
                CFG_TGT_LEN: r_tgt_len <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_char_out  = r_char;
    assign o_last      = r_last;
    assign o_invalid   = r_invalid;

endmodule

@@ rtl/core/rsc_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rsc_checker
// Port-level checks on the result stream of the radix string converter.
// ============================================================================
module rsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_char_out,
    input logic       o_last,
    input logic       o_invalid
);
    import rsc_pkg::*;

    // invalid result is a single empty closing item
    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_last && o_char_out == CH_NUL))
        else $error("invalid result not a lone closing item");

    // number finished means the block is free again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy after final result");

    // more results to come keeps the block busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("not busy with results pending");

    // a valid minus is only ever the sign, never the closing digit
    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid && o_char_out == CH_MINUS) |-> !o_last)
        else $error("minus as final character");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_char_out (o_char_out),
    .o_last     (o_last),
    .o_invalid  (o_invalid)
);
